>>> src/tlptu_pkg.sv
// Shared types and constants for the two-level page table updater.
// No dependencies; every other file of the block but tlptu_ram imports this package.
package tlptu_pkg;

    // Request kinds
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_MAP     = 2'd1;
    localparam logic [1:0] KIND_PROTECT = 2'd2;
    localparam logic [1:0] KIND_UNMAP   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_LARGE      = 2'd1;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd2;
    localparam logic [1:0] ST_NO_SLOT    = 2'd3;

    // Entry flag bits
    localparam logic [31:0] PG_PRESENT  = 32'h0000_0001;
    localparam logic [31:0] PG_WRITABLE = 32'h0000_0002;
    localparam logic [31:0] PG_USER     = 32'h0000_0004;
    localparam logic [31:0] PG_LARGE    = 32'h0000_0080;
    localparam logic [31:0] LOW_MASK    = 32'h0000_0FFF;

    localparam int IDX_W      = 10;
    localparam int FRAME_W    = 20;
    localparam int DIR_DEPTH  = 1024;
    localparam int TBL_WORDS  = 1024;

    // Configuration port
    localparam int         CFG_IDX_W        = 1;
    localparam int         CFG_DATA_W       = 20;
    localparam logic [0:0] CFG_TABLE_REGION = 1'b0;
    localparam logic [0:0] CFG_DIR_ACTIVE   = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] virt_addr;
        logic [31:0] phys_addr;
        logic [11:0] page_flags;
        logic [31:0] directory_entry;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        flush_tlb;
        logic [31:0] entry_written;
    } rsp_t;

    // What goes into entry_written and into a table write
    typedef enum logic [1:0] {
        SEL_ZERO    = 2'd0,
        SEL_DENT    = 2'd1,
        SEL_MAP     = 2'd2,
        SEL_PROTECT = 2'd3
    } entry_sel_t;

    typedef enum logic [1:0] {
        FL_CLEAR  = 2'd0,
        FL_SET    = 2'd1,
        FL_ACTIVE = 2'd2
    } flush_sel_t;

    typedef struct packed {
        logic       init_step;    // zero one directory entry
        logic       take;         // latch the request
        logic       dir_access;   // read directory, or write it on load
        logic       capture_slot;
        logic       alloc;        // link a new table from the pool
        logic       tclr_step;    // zero one entry of the new table
        logic       tbl_read;
        logic       tbl_write;
        logic       set_res;
        logic [1:0] res_status;
        entry_sel_t res_entry;
        flush_sel_t res_flush;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       large_page;   // directory entry has the large-page bit
        logic       present;
        logic       slot_ok;
        logic       pool_full;
        logic       pte_present;
        logic       clr_last;
    } dp_status_t;

endpackage

>>> src/tlptu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tlptu_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> src/tlptu_datapath.sv
// Datapath: config registers, directory and table RAMs, slot pool, result registers.
// Depends on tlptu_pkg and tlptu_ram.
module tlptu_datapath #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tlptu_pkg::dp_cmd_t                   cmd,
    output tlptu_pkg::dp_status_t                stat,
    input  tlptu_pkg::req_t                      s_data,
    input  logic                                 cfg_we,
    input  logic [tlptu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlptu_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tlptu_pkg::rsp_t                      m_data
);
    import tlptu_pkg::*;

    localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W    = $clog2(TABLE_SLOTS + 1);
    localparam int TBL_DEPTH = TABLE_SLOTS * TBL_WORDS;
    localparam int TADDR_W  = $clog2(TBL_DEPTH);

    logic [FRAME_W-1:0] region_reg;
    logic               active_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   clr_cnt_reg;
    req_t               req_reg;
    logic [SLOT_W-1:0]  slot_reg;
    rsp_t               res_reg;
    rsp_t               out_reg;

    logic [IDX_W-1:0]   pdi;
    logic [IDX_W-1:0]   pti;
    logic [31:0]        dir_rdata;
    logic [31:0]        tbl_rdata;
    logic [FRAME_W-1:0] slot_off;
    logic [FRAME_W-1:0] new_frame;
    logic [31:0]        new_pde;
    logic [31:0]        map_pte;
    logic [31:0]        prot_pte;
    logic [31:0]        entry_val;
    logic               flush_val;

    logic               dir_we;
    logic [IDX_W-1:0]   dir_waddr;
    logic [31:0]        dir_wdata;
    logic               tbl_we;
    logic [TADDR_W-1:0] tbl_addr_rw;
    logic [TADDR_W-1:0] tbl_addr_clr;
    logic [TADDR_W-1:0] tbl_waddr;
    logic [31:0]        tbl_wdata;

    assign pdi = req_reg.virt_addr[31:22];
    assign pti = req_reg.virt_addr[21:12];

    // Slot that a directory entry points to, relative to the pool base
    assign slot_off  = dir_rdata[31:12] - region_reg;
    assign new_frame = region_reg + FRAME_W'(count_reg);
    assign new_pde   = {new_frame, 12'h000} | PG_PRESENT | PG_WRITABLE | PG_USER;
    assign map_pte   = (req_reg.phys_addr & ~LOW_MASK) | {20'h0, req_reg.page_flags}
                       | PG_PRESENT;
    assign prot_pte  = (tbl_rdata & ~LOW_MASK) | {20'h0, req_reg.page_flags} | PG_PRESENT;

    always_comb begin
        unique case (cmd.res_entry)
            SEL_ZERO:    entry_val = 32'h0;
            SEL_DENT:    entry_val = req_reg.directory_entry;
            SEL_MAP:     entry_val = map_pte;
            SEL_PROTECT: entry_val = prot_pte;
            default:     entry_val = 32'h0;
        endcase
    end

    always_comb begin
        unique case (cmd.res_flush)
            FL_CLEAR:  flush_val = 1'b0;
            FL_SET:    flush_val = 1'b1;
            FL_ACTIVE: flush_val = active_reg;
            default:   flush_val = 1'b0;
        endcase
    end

    // Directory write port
    always_comb begin
        dir_we    = 1'b0;
        dir_waddr = pdi;
        dir_wdata = 32'h0;
        priority if (cmd.init_step) begin
            dir_we    = 1'b1;
            dir_waddr = clr_cnt_reg;
        end else if (cmd.dir_access && req_reg.kind == KIND_LOAD) begin
            dir_we    = 1'b1;
            dir_wdata = req_reg.directory_entry;
        end else if (cmd.alloc) begin
            dir_we    = 1'b1;
            dir_wdata = new_pde;
        end
    end

    // Table write port: clearing sweep or a single entry update
    assign tbl_addr_rw  = TADDR_W'({slot_reg, pti});
    assign tbl_addr_clr = TADDR_W'({slot_reg, clr_cnt_reg});
    assign tbl_we       = cmd.tclr_step | cmd.tbl_write;
    assign tbl_waddr    = cmd.tclr_step ? tbl_addr_clr : tbl_addr_rw;
    assign tbl_wdata    = cmd.tclr_step ? 32'h0 : entry_val;

    tlptu_ram #(
        .WIDTH (32),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .aclk  (aclk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (cmd.dir_access),
        .raddr (pdi),
        .rdata (dir_rdata)
    );

    tlptu_ram #(
        .WIDTH (32),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (cmd.tbl_read),
        .raddr (tbl_addr_rw),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg  <= '0;
            active_reg  <= 1'b0;
            count_reg   <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TABLE_REGION: region_reg <= cfg_data;
                    CFG_DIR_ACTIVE:   active_reg <= cfg_data[0];
                endcase
            end
            if (cmd.alloc) begin
                count_reg   <= count_reg + CNT_W'(1);
                clr_cnt_reg <= '0;
            end else if (cmd.init_step || cmd.tclr_step) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            req_reg <= s_data;
        end
        if (cmd.capture_slot) begin
            slot_reg <= cmd.alloc ? SLOT_W'(count_reg) : SLOT_W'(slot_off);
        end
        if (cmd.set_res) begin
            res_reg <= '{status: cmd.res_status, flush_tlb: flush_val,
                         entry_written: entry_val};
        end
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
    end

    assign stat.kind        = req_reg.kind;
    assign stat.large_page  = (dir_rdata & PG_LARGE) != 32'h0;
    assign stat.present     = (dir_rdata & PG_PRESENT) != 32'h0;
    assign stat.slot_ok     = slot_off < FRAME_W'(count_reg);
    assign stat.pool_full   = count_reg == CNT_W'(TABLE_SLOTS);
    assign stat.pte_present = (tbl_rdata & PG_PRESENT) != 32'h0;
    assign stat.clr_last    = &clr_cnt_reg;

    assign m_data = out_reg;
endmodule

>>> src/tlptu_controller.sv
// Controller state machine: sequences directory and table accesses per request.
// Depends on tlptu_pkg.
module tlptu_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  tlptu_pkg::dp_status_t stat,
    output tlptu_pkg::dp_cmd_t    cmd
);
    import tlptu_pkg::*;

    typedef enum logic [9:0] {
        S_INIT  = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_DIR   = 10'b00_0000_0100,
        S_CHECK = 10'b00_0000_1000,
        S_TCLR  = 10'b00_0001_0000,
        S_TWR   = 10'b00_0010_0000,
        S_TRD   = 10'b00_0100_0000,
        S_TCHK  = 10'b00_1000_0000,
        S_DONE  = 10'b01_0000_0000,
        S_SPARE = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg;

    always_comb begin
        cmd           = '0;
        cmd.res_entry = SEL_ZERO;
        cmd.res_flush = FL_CLEAR;
        state_next    = state_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = S_DIR;
                end
            end
            S_DIR: begin
                cmd.dir_access = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK: begin
                cmd.capture_slot = 1'b1;
                state_next       = S_DONE;
                priority if (stat.kind == KIND_LOAD) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_entry  = SEL_DENT;
                end else if (stat.large_page) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_LARGE;
                end else if (stat.kind == KIND_MAP && !stat.present) begin
                    if (stat.pool_full) begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_NO_SLOT;
                    end else begin
                        cmd.alloc  = 1'b1;
                        state_next = S_TCLR;
                    end
                end else if (!stat.present || !stat.slot_ok) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_NOT_MAPPED;
                end else if (stat.kind == KIND_MAP) begin
                    state_next = S_TWR;
                end else begin
                    state_next = S_TRD;
                end
            end
            S_TCLR: begin
                cmd.tclr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_TWR;
                end
            end
            S_TWR: begin
                cmd.tbl_write  = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_entry  = SEL_MAP;
                state_next     = S_DONE;
            end
            S_TRD: begin
                cmd.tbl_read = 1'b1;
                state_next   = S_TCHK;
            end
            S_TCHK: begin
                cmd.set_res = 1'b1;
                state_next  = S_DONE;
                if (!stat.pte_present) begin
                    cmd.res_status = ST_NOT_MAPPED;
                end else if (stat.kind == KIND_PROTECT) begin
                    cmd.tbl_write  = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_entry  = SEL_PROTECT;
                    cmd.res_flush  = FL_SET;
                end else begin
                    cmd.tbl_write  = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_flush  = FL_ACTIVE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
endmodule

>>> src/two_level_page_table_updater_unit.sv
// Top level of the two-level page table updater: controller plus datapath.
// Depends on tlptu_pkg, tlptu_controller and tlptu_datapath.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  -------------------------------------
//  s_       in   s_valid / s_ready  req_t: kind, addresses, flags, entry
//  m_       out  m_valid / m_ready  rsp_t: status, flush_tlb, entry_written
//  cfg_     in   cfg_we             cfg_index selects region or active bit
//
// One request at a time. Load, large page and early errors end at the directory
// check; map into an existing table adds a table write; protect and unmap add a
// table read and write; a map that allocates a table first zeroes the new slot.
// s_ready rises with m_valid, so the next request can be taken while that result is offered.
// After reset a pass zeroes the directory RAM; s_ready stays low meanwhile.
// A stalled result sits in the output register; the next request is taken
// meanwhile and waits at its final step until that register frees.
module two_level_page_table_updater_unit #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  tlptu_pkg::req_t                      s_data,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tlptu_pkg::rsp_t                      m_data,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [tlptu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlptu_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tlptu_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    // Sequencing: init sweep, directory read, decision, table access, result
    tlptu_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage, slot arithmetic and entry formatting
    tlptu_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );
endmodule

>>> src/tlptu_checker.sv
// Port-level checks of the page table updater, bound to its top level.
// Depends on tlptu_pkg and two_level_page_table_updater_unit.
module tlptu_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input tlptu_pkg::req_t s_data,
    input logic            m_valid,
    input logic            m_ready,
    input tlptu_pkg::rsp_t m_data
);
    import tlptu_pkg::*;

    // A held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Failed requests write nothing and flush nothing
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
            m_data.entry_written == 32'h0 && !m_data.flush_tlb)
        else $error("error result carries an entry or a flush");

    // A flush with a nonzero entry comes from protect, which keeps it present
    a_flush_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.flush_tlb && m_data.entry_written != 32'h0 |->
            m_data.entry_written[0])
        else $error("protected entry without present bit");

    // The directory clearing pass blocks requests right after reset
    a_init_block: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block ready during directory clearing");

    // One request at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");
endmodule

bind two_level_page_table_updater_unit tlptu_checker u_tlptu_checker (.*);

>>> tb/tb.sv
// Testbench for two_level_page_table_updater_unit: random and directed requests
// checked against a shadow copy of the directory and table pool.
// Depends on tlptu_pkg and the RTL of the unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlptu_pkg::*;

    localparam int TABLE_SLOTS    = 16;
    localparam int PHASES         = 6;
    localparam int PHASE_REQS     = 225;
    // Longest legal quiet stretch: reset sweep or table clear plus both sides
    // idling at their longest waits; taken many times over.
    localparam int IDLE_LIMIT     = 20000;

    // Shadow of the directory, the table pool and the two registers.
    // note_request predicts the response of each accepted request;
    // check_result compares a response with the oldest prediction.
    class page_table_shadow;
        logic [31:0]        dir_mem [DIR_DEPTH];
        logic [31:0]        pt_mem  [TABLE_SLOTS*TBL_WORDS];
        int unsigned        slots_used;
        logic [FRAME_W-1:0] region;
        bit                 active;
        rsp_t               pending_rsp [$];
        int                 errors;

        function new();
            foreach (dir_mem[i]) dir_mem[i] = '0;
            foreach (pt_mem[i]) pt_mem[i] = '0;
            slots_used = 0;
            region     = '0;
            active     = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_TABLE_REGION) begin
                region = val;
            end else begin
                active = val[0];
            end
        endfunction

        // Slot a directory entry points at under the current region, or -1.
        function int slot_of(logic [31:0] pde);
            logic [FRAME_W-1:0] s;
            s = pde[31:12] - region;
            if (s < TABLE_SLOTS && s < slots_used) return int'(s);
            return -1;
        endfunction

        function void note_request(req_t r);
            logic [IDX_W-1:0]   pdi;
            logic [IDX_W-1:0]   pti;
            logic [31:0]        pde;
            logic [31:0]        pte;
            logic [FRAME_W-1:0] frame;
            int                 slot;
            int unsigned        pos;
            rsp_t               e;
            pdi = r.virt_addr[31:22];
            pti = r.virt_addr[21:12];
            e   = '0;
            e.status = ST_OK;
            if (r.kind == KIND_LOAD) begin
                dir_mem[pdi]    = r.directory_entry;
                e.entry_written = r.directory_entry;
            end else begin
                pde = dir_mem[pdi];
                if ((pde & PG_LARGE) != 0) begin
                    // large pages are left alone, present or not
                    e.status = ST_LARGE;
                end else if (r.kind == KIND_MAP) begin
                    if ((pde & PG_PRESENT) == 0) begin
                        if (slots_used >= TABLE_SLOTS) begin
                            e.status = ST_NO_SLOT;
                        end else begin
                            for (int i = 0; i < TBL_WORDS; i++)
                                pt_mem[slots_used*TBL_WORDS + i] = '0;
                            frame = region + FRAME_W'(slots_used);
                            slots_used++;
                            pde = {frame, 12'h000} | PG_PRESENT | PG_WRITABLE | PG_USER;
                            dir_mem[pdi] = pde;
                        end
                    end
                    if (e.status == ST_OK) begin
                        slot = slot_of(pde);
                        if (slot < 0) begin
                            e.status = ST_NOT_MAPPED;
                        end else begin
                            pte = {r.phys_addr[31:12], r.page_flags} | PG_PRESENT;
                            pt_mem[slot*TBL_WORDS + int'(pti)] = pte;
                            e.entry_written = pte;
                        end
                    end
                end else begin
                    slot = ((pde & PG_PRESENT) != 0) ? slot_of(pde) : -1;
                    pos  = (slot < 0) ? 0 : slot*TBL_WORDS + int'(pti);
                    pte  = pt_mem[pos];
                    if (slot < 0 || (pte & PG_PRESENT) == 0) begin
                        e.status = ST_NOT_MAPPED;
                    end else if (r.kind == KIND_PROTECT) begin
                        pte = {pte[31:12], r.page_flags} | PG_PRESENT;
                        pt_mem[pos]     = pte;
                        e.flush_tlb     = 1'b1;
                        e.entry_written = pte;
                    end else begin
                        pt_mem[pos] = '0;
                        e.flush_tlb = active;
                    end
                end
            end
            pending_rsp.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            if (pending_rsp.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display({"tb: response with no request pending: ",
                              "status=%0d flush=%0b entry=%08h"},
                             got.status, got.flush_tlb, got.entry_written);
                return;
            end
            exp = pending_rsp.pop_front();
            if (got.status !== exp.status || got.flush_tlb !== exp.flush_tlb ||
                got.entry_written !== exp.entry_written) begin
                errors++;
                if (errors <= 10)
                    $display({"tb: mismatch exp status=%0d flush=%0b entry=%08h, ",
                              "got status=%0d flush=%0b entry=%08h"},
                             exp.status, exp.flush_tlb, exp.entry_written,
                             got.status, got.flush_tlb, got.entry_written);
            end
        endfunction

        function void flag_leftovers();
            if (pending_rsp.size() != 0) begin
                errors += pending_rsp.size();
                $display("tb: %0d requests never answered", pending_rsp.size());
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    req_t                  s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rsp_t                  m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    page_table_shadow ps = new();

    int  idle_cycles = 0;
    // idle pattern per side: a run of items either with random waits or none
    int  s_left = 0;
    bit  s_calm = 1'b0;
    int  m_left = 0;
    bit  m_calm = 1'b0;

    two_level_page_table_updater_unit #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Wait count for one item; every 20..80 items the side flips a coin
    // (one in four) for a stretch with no waits at all.
    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(20, 80);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic req_t mk_req(logic [1:0] kind, logic [9:0] pdi, logic [9:0] pti,
                                    logic [31:0] phys, logic [11:0] flags,
                                    logic [31:0] dent);
        req_t r;
        r.kind            = kind;
        r.virt_addr       = {pdi, pti, 12'($urandom)};
        r.phys_addr       = phys;
        r.page_flags      = flags;
        r.directory_entry = dent;
        return r;
    endfunction

    // Entered and left at a rising edge; valid stays up across a zero gap.
    task automatic send_req(req_t r);
        int gap;
        gap = draw_wait(s_left, s_calm);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        ps.note_request(r);
    endtask

    task automatic write_regs(logic [FRAME_W-1:0] region, bit active);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TABLE_REGION;
        cfg_data  <= region;
        @(posedge aclk);
        ps.set_reg(CFG_TABLE_REGION, region);
        cfg_index <= CFG_DIR_ACTIVE;
        cfg_data  <= CFG_DATA_W'(active);
        @(posedge aclk);
        ps.set_reg(CFG_DIR_ACTIVE, CFG_DATA_W'(active));
        cfg_we <= 1'b0;
    endtask

    // Entered at the accepting edge of the last request: drop valid so that
    // request is not offered again, then wait for every response.
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (ps.pending_rsp.size() != 0) @(posedge aclk);
    endtask

    // Response side: random stall before each response, then take it.
    initial begin
        int stall;
        forever begin
            stall = draw_wait(m_left, m_calm);
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            ps.check_result(m_data);
        end
    end

    // Watchdog: quiet cycles with no request and no response moving.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        req_t               r;
        int                 v;
        int                 idx;
        int                 slot;
        logic [FRAME_W-1:0] reg_v;
        bit                 act_v;
        logic [FRAME_W-1:0] frame;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // the unit sweeps its directory after reset; s_ready holds off requests
        write_regs('0, 1'b0);

        // ---- directed requests, region 0, directory inactive ----
        // first map allocates slot 0; extremes of frame and flags
        send_req(mk_req(KIND_MAP, 10'd0, 10'd0, 32'h0000_0000, 12'h000, 32'h0));
        send_req(mk_req(KIND_MAP, 10'd0, 10'd1023, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF));
        // protect forces present on even when the flags clear it
        send_req(mk_req(KIND_PROTECT, 10'd0, 10'd0, 32'h0, 12'hFFE, 32'h0));
        send_req(mk_req(KIND_PROTECT, 10'd0, 10'd5, 32'h0, 12'h123, 32'h0));     // absent page
        send_req(mk_req(KIND_UNMAP, 10'd0, 10'd0, 32'h0, 12'h0, 32'h0));         // no flush, inactive
        send_req(mk_req(KIND_UNMAP, 10'd0, 10'd0, 32'h0, 12'h0, 32'h0));         // already gone
        send_req(mk_req(KIND_PROTECT, 10'd1023, 10'd7, 32'h0, 12'h0, 32'h0));    // absent table
        send_req(mk_req(KIND_UNMAP, 10'd1023, 10'd7, 32'h0, 12'h0, 32'h0));
        // large bit with present clear still blocks every walk
        send_req(mk_req(KIND_LOAD, 10'd1023, 10'd0, 32'h0, 12'h0, 32'h0000_0080));
        send_req(mk_req(KIND_MAP, 10'd1023, 10'd2, 32'h1234_5000, 12'h007, 32'h0));
        send_req(mk_req(KIND_PROTECT, 10'd1023, 10'd2, 32'h0, 12'h003, 32'h0));
        send_req(mk_req(KIND_UNMAP, 10'd1023, 10'd2, 32'h0, 12'h0, 32'h0));
        send_req(mk_req(KIND_LOAD, 10'd5, 10'd0, 32'h0, 12'h0, 32'hFFFF_FFFF));
        send_req(mk_req(KIND_MAP, 10'd5, 10'd9, 32'hABCD_E000, 12'h001, 32'h0));
        // present entry pointing outside the pool cannot be walked
        send_req(mk_req(KIND_LOAD, 10'd6, 10'd0, 32'h0, 12'h0, 32'h0012_3007));
        send_req(mk_req(KIND_MAP, 10'd6, 10'd1, 32'h5555_5000, 12'h002, 32'h0));
        send_req(mk_req(KIND_PROTECT, 10'd6, 10'd1, 32'h0, 12'h002, 32'h0));
        send_req(mk_req(KIND_UNMAP, 10'd6, 10'd1, 32'h0, 12'h0, 32'h0));
        // second directory entry sharing slot 0
        send_req(mk_req(KIND_LOAD, 10'd7, 10'd0, 32'h0, 12'h0, 32'h0000_0007));
        send_req(mk_req(KIND_MAP, 10'd7, 10'd3, 32'h8000_0000, 12'h800, 32'h0));
        send_req(mk_req(KIND_PROTECT, 10'd7, 10'd1023, 32'h0, 12'h555, 32'h0));
        // link to slot 1 before it is allocated, then after
        send_req(mk_req(KIND_LOAD, 10'd8, 10'd0, 32'h0, 12'h0, 32'h0000_1007));
        send_req(mk_req(KIND_MAP, 10'd8, 10'd4, 32'h0000_1000, 12'h0AA, 32'h0));
        send_req(mk_req(KIND_MAP, 10'd9, 10'd4, 32'h0000_2000, 12'h0AA, 32'h0));
        send_req(mk_req(KIND_MAP, 10'd8, 10'd4, 32'h0000_3000, 12'h0AA, 32'h0));

        // ---- random phases, each under its own register setting ----
        for (int p = 0; p < PHASES; p++) begin
            // sender holds until every response is in, then reprograms
            wait_drain();
            case (p)
                0: begin reg_v = 20'hFFFFF; act_v = 1'b1; end
                1: begin reg_v = 20'h00000; act_v = 1'b1; end
                2: begin reg_v = 20'($urandom); act_v = 1'b0; end
                3: begin reg_v = 20'hFFFFF; act_v = 1'b0; end
                4: begin reg_v = 20'($urandom); act_v = 1'b1; end
                default: begin reg_v = 20'h00000; act_v = 1'b0; end
            endcase
            write_regs(reg_v, act_v);

            for (int n = 0; n < PHASE_REQS; n++) begin
                r.virt_addr       = $urandom;
                r.phys_addr       = $urandom;
                r.page_flags      = 12'($urandom);
                r.directory_entry = $urandom;
                v = $urandom_range(0, 99);
                r.kind = (v < 20) ? KIND_LOAD : (v < 55) ? KIND_MAP :
                         (v < 80) ? KIND_PROTECT : KIND_UNMAP;
                // mostly a few hot directory and table indexes, edges included,
                // so protect and unmap land on mapped pages
                v = $urandom_range(0, 19);
                if (v < 17) begin
                    idx = v % 8;
                    r.virt_addr[31:22] = (idx < 4) ? 10'(idx) : 10'(1016 + idx);
                end
                v = $urandom_range(0, 39);
                if (v < 34) begin
                    idx = v % 16;
                    r.virt_addr[21:12] = (idx < 8) ? 10'(idx) : 10'(1008 + idx);
                end
                if (r.kind == KIND_LOAD) begin
                    v = $urandom_range(0, 9);
                    if (v < 5) begin
                        // link into the pool; now and then a slot not yet taken
                        if (ps.slots_used > 0 && v < 4)
                            slot = $urandom_range(0, ps.slots_used - 1);
                        else
                            slot = $urandom_range(0, TABLE_SLOTS);
                        frame = ps.region + FRAME_W'(slot);
                        r.directory_entry = {frame,
                            (r.directory_entry[11:0] & ~12'h080) | 12'h001};
                    end else if (v < 7) begin
                        r.directory_entry = r.directory_entry | PG_LARGE;
                    end else if (v < 8) begin
                        r.directory_entry = r.directory_entry & ~(PG_LARGE | PG_PRESENT);
                    end
                end
                send_req(r);
            end
        end

        wait_drain();
        // let any stray response show up
        repeat (64) @(posedge aclk);
        ps.flag_leftovers();
        if (ps.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
src/tlptu_pkg.sv
src/tlptu_ram.sv
src/tlptu_datapath.sv
src/tlptu_controller.sv
src/two_level_page_table_updater_unit.sv
src/tlptu_checker.sv
tb/tb.sv
